// ===== sv/wfse_pkg.sv =====
// shared types and constants for the wall-follow steering and encoder block
// no dependencies; imported by wall_follow_steering_encoders_top
package wfse_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 10;
   localparam int DUTY_BITS      = 10;
   localparam int GAIN_BITS      = 8;
   localparam int PIN_BITS       = 4;

   // register map of the configuration port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GAIN         = 3'd0,
      CSR_BASE_DUTY    = 3'd1,
      CSR_MIN_DUTY     = 3'd2,
      CSR_MAX_DUTY     = 3'd3,
      CSR_CLOSEST_WALL = 3'd4,
      CSR_TARGET_WALL  = 3'd5,
      CSR_NO_WALL      = 3'd6
   } csr_index_type;

   // item kinds on the request channel
   typedef enum logic {
      OP_ENCODER = 1'b0,
      OP_STEER   = 1'b1
   } op_type;

   localparam logic [GAIN_BITS-1:0] GAIN_RESET         = 8'd8;
   localparam logic [DUTY_BITS-1:0] BASE_DUTY_RESET    = 10'd200;
   localparam logic [DUTY_BITS-1:0] MIN_DUTY_RESET     = 10'd150;
   localparam logic [DUTY_BITS-1:0] MAX_DUTY_RESET     = 10'd300;
   localparam logic [DUTY_BITS-1:0] CLOSEST_WALL_RESET = 10'd450;
   localparam logic [DUTY_BITS-1:0] TARGET_WALL_RESET  = 10'd240;
   localparam logic [DUTY_BITS-1:0] NO_WALL_RESET      = 10'd150;

endpackage

// ===== sv/wall_follow_steering_encoders_top.sv =====
// wall-follow steering controller with quadrature encoder counters
// depends on wfse_pkg (register map, item kinds, reset values)
//
// request channel (req_*): a beat is an encoder pin sample (req_op = encoder)
// or a steer request (req_op = steer). a pin sample steps both motor counters
// and gives no response. a steer request picks a correction source (front-left
// wall, front-right wall, side balance, encoder difference), scales it by the
// gain, clamps both duties and clears the counters
// response channel (rsp_*): one beat per steer request, in order
// csr port: write-only, taken at any edge with csr_we high; the user must
// write only while idle, the block itself does not enforce it
// timing: one request beat per cycle of either kind while req_stall is low;
// a steer request passes stage one, which holds the chosen difference and
// directions, then the response register: clamped duties after the gain multiply
// reset: synchronous, clears counters and last pins, loads register defaults
// and empties both stages
// stall: rsp_stall holds the response register; stage one still fills behind
// it, then req_stall rises until the response beat is taken
module wall_follow_steering_encoders_top #(
   parameter int SENSOR_BITS = 10,
   parameter int COUNT_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_we,
   input  logic [wfse_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [wfse_pkg::CSR_DATA_BITS-1:0]   csr_data,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic [wfse_pkg::PIN_BITS-1:0]        req_encoder_pins,
   input  logic [SENSOR_BITS-1:0]               req_side_left,
   input  logic [SENSOR_BITS-1:0]               req_diag_left,
   input  logic [SENSOR_BITS-1:0]               req_diag_right,
   input  logic [SENSOR_BITS-1:0]               req_side_right,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [wfse_pkg::DUTY_BITS-1:0]       rsp_left_duty,
   output logic [wfse_pkg::DUTY_BITS-1:0]       rsp_right_duty,
   output logic                                 rsp_left_reverse,
   output logic                                 rsp_right_reverse
);
   import wfse_pkg::*;

   // sensor values compared against 10-bit thresholds
   localparam int CMP_BITS   = (SENSOR_BITS > DUTY_BITS) ? SENSOR_BITS : DUTY_BITS;
   // signed difference wide enough for a sensor or a counter difference
   localparam int DELTA_BITS = ((CMP_BITS > COUNT_BITS) ? CMP_BITS : COUNT_BITS) + 2;
   // gain (unsigned, one sign bit added) times difference
   localparam int PROD_BITS  = DELTA_BITS + GAIN_BITS + 1;
   // base*16 plus or minus the product
   localparam int SUM_BITS   = PROD_BITS + 1;

   localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
   localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

   // configuration registers
   logic [GAIN_BITS-1:0] gain_ff;
   logic [DUTY_BITS-1:0] base_duty_ff, min_duty_ff, max_duty_ff;
   logic [DUTY_BITS-1:0] closest_wall_ff, target_wall_ff, no_wall_ff;

   // encoder state
   logic signed [COUNT_BITS-1:0] count_one_ff, count_two_ff;
   logic signed [COUNT_BITS-1:0] count_one_in, count_two_in;
   logic [1:0]                   last_one_ff, last_two_ff;

   // first stage: chosen difference and directions
   logic                         s1_valid_ff, s1_valid_in;
   logic signed [DELTA_BITS-1:0] s1_delta_ff, s1_delta_in;
   logic                         s1_lrev_ff, s1_lrev_in;
   logic                         s1_rrev_ff, s1_rrev_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DUTY_BITS-1:0] rsp_left_ff, rsp_left_in;
   logic [DUTY_BITS-1:0] rsp_right_ff, rsp_right_in;
   logic                 rsp_lrev_ff, rsp_rrev_ff;

   logic req_acc, enc_acc, steer_acc;
   logic out_free, s1_free;

   logic [CMP_BITS:0]            sl_w, dl_w, dr_w, sr_w;
   logic [CMP_BITS:0]            closest_w, target_w, no_wall_w;
   logic signed [DELTA_BITS-1:0] sl_s, dl_s, dr_s, sr_s, target_s;
   logic signed [DELTA_BITS-1:0] cnt_one_s, cnt_two_s;

   logic signed [PROD_BITS-1:0]  gain_s, delta_s, prod;
   logic signed [SUM_BITS-1:0]   base_s, left_sum, right_sum;

   // quadrature step: +1, -1 or 0 as two bits (move, down)
   function automatic logic [1:0] decode(input logic [1:0] now, input logic [1:0] prev);
      logic [1:0] d;
      logic       move;
      logic       down;
      d    = now ^ prev;
      move = (d == 2'b01) || (d == 2'b10);
      down = prev[0] ^ now[1];
      return {move, down};
   endfunction

   // saturating step by one
   function automatic logic signed [COUNT_BITS-1:0] step_count(
         input logic signed [COUNT_BITS-1:0] c, input logic move, input logic down);
      logic signed [COUNT_BITS-1:0] r;
      r = c;
      if (move && down && (c != COUNT_MIN)) begin
         r = c - COUNT_BITS'(1);
      end else if (move && !down && (c != COUNT_MAX)) begin
         r = c + COUNT_BITS'(1);
      end
      return r;
   endfunction

   // divide by 16 toward zero, then clamp (upper bound checked first)
   function automatic logic [DUTY_BITS-1:0] finish(input logic signed [SUM_BITS-1:0] x,
         input logic [DUTY_BITS-1:0] lo, input logic [DUTY_BITS-1:0] hi);
      logic signed [SUM_BITS-1:0] q;
      logic signed [SUM_BITS-1:0] lo_s;
      logic signed [SUM_BITS-1:0] hi_s;
      logic [DUTY_BITS-1:0]       r;
      q    = x[SUM_BITS-1] ? ((x + SUM_BITS'(15)) >>> 4) : (x >>> 4);
      lo_s = $signed({{(SUM_BITS-DUTY_BITS){1'b0}}, lo});
      hi_s = $signed({{(SUM_BITS-DUTY_BITS){1'b0}}, hi});
      if (q > hi_s) begin
         r = hi;
      end else if (q < lo_s) begin
         r = lo;
      end else begin
         r = q[DUTY_BITS-1:0];
      end
      return r;
   endfunction

   // handshake: response register frees when empty or taken, stage one
   // frees when empty or moving into the response register
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req_stall = !s1_free;
   assign req_acc   = req_valid && !req_stall;
   assign enc_acc   = req_acc && (req_op == OP_ENCODER);
   assign steer_acc = req_acc && (req_op == OP_STEER);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff         <= GAIN_RESET;
         base_duty_ff    <= BASE_DUTY_RESET;
         min_duty_ff     <= MIN_DUTY_RESET;
         max_duty_ff     <= MAX_DUTY_RESET;
         closest_wall_ff <= CLOSEST_WALL_RESET;
         target_wall_ff  <= TARGET_WALL_RESET;
         no_wall_ff      <= NO_WALL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN:         gain_ff         <= csr_data[GAIN_BITS-1:0];
            CSR_BASE_DUTY:    base_duty_ff    <= csr_data;
            CSR_MIN_DUTY:     min_duty_ff     <= csr_data;
            CSR_MAX_DUTY:     max_duty_ff     <= csr_data;
            CSR_CLOSEST_WALL: closest_wall_ff <= csr_data;
            CSR_TARGET_WALL:  target_wall_ff  <= csr_data;
            CSR_NO_WALL:      no_wall_ff      <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // encoder counters: motor two counts with opposite sign, steer clears both
   always_comb begin
      logic [1:0] st1;
      logic [1:0] st2;
      st1          = decode(req_encoder_pins[1:0], last_one_ff);
      st2          = decode(req_encoder_pins[3:2], last_two_ff);
      count_one_in = count_one_ff;
      count_two_in = count_two_ff;
      if (steer_acc) begin
         count_one_in = '0;
         count_two_in = '0;
      end else if (enc_acc) begin
         count_one_in = step_count(count_one_ff, st1[1], st1[0]);
         count_two_in = step_count(count_two_ff, st2[1], !st2[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_one_ff <= '0;
         count_two_ff <= '0;
         last_one_ff  <= '0;
         last_two_ff  <= '0;
      end else begin
         count_one_ff <= count_one_in;
         count_two_ff <= count_two_in;
         if (enc_acc) begin
            last_one_ff <= req_encoder_pins[1:0];
            last_two_ff <= req_encoder_pins[3:2];
         end
      end
   end

   // stage one: pick the correction source
   assign sl_w      = (CMP_BITS+1)'(req_side_left);
   assign dl_w      = (CMP_BITS+1)'(req_diag_left);
   assign dr_w      = (CMP_BITS+1)'(req_diag_right);
   assign sr_w      = (CMP_BITS+1)'(req_side_right);
   assign closest_w = (CMP_BITS+1)'(closest_wall_ff);
   assign target_w  = (CMP_BITS+1)'(target_wall_ff);
   assign no_wall_w = (CMP_BITS+1)'(no_wall_ff);

   assign sl_s      = $signed(DELTA_BITS'(sl_w));
   assign dl_s      = $signed(DELTA_BITS'(dl_w));
   assign dr_s      = $signed(DELTA_BITS'(dr_w));
   assign sr_s      = $signed(DELTA_BITS'(sr_w));
   assign target_s  = $signed(DELTA_BITS'(target_w));
   assign cnt_one_s = {{(DELTA_BITS-COUNT_BITS){count_one_ff[COUNT_BITS-1]}}, count_one_ff};
   assign cnt_two_s = {{(DELTA_BITS-COUNT_BITS){count_two_ff[COUNT_BITS-1]}}, count_two_ff};

   always_comb begin
      s1_lrev_in = 1'b0;
      s1_rrev_in = 1'b0;
      priority if (dl_w > closest_w) begin
         s1_delta_in = dl_s - target_s;
         s1_rrev_in  = 1'b1;
      end else if (dr_w > closest_w) begin
         s1_delta_in = target_s - dr_s;
         s1_lrev_in  = 1'b1;
      end else if ((sl_w > no_wall_w) && (sr_w > no_wall_w)) begin
         s1_delta_in = sl_s - sr_s;
      end else begin
         s1_delta_in = cnt_two_s - cnt_one_s;
      end
   end

   assign s1_valid_in = s1_free ? steer_acc : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (steer_acc) begin
         s1_delta_ff <= s1_delta_in;
         s1_lrev_ff  <= s1_lrev_in;
         s1_rrev_ff  <= s1_rrev_in;
      end
   end

   // stage two: gain multiply, add to base*16, scale back and clamp
   assign gain_s    = $signed({{(PROD_BITS-GAIN_BITS){1'b0}}, gain_ff});
   assign delta_s   = {{(PROD_BITS-DELTA_BITS){s1_delta_ff[DELTA_BITS-1]}}, s1_delta_ff};
   assign prod      = gain_s * delta_s;
   assign base_s    = $signed({{(SUM_BITS-DUTY_BITS-4){1'b0}}, base_duty_ff, 4'b0000});
   assign left_sum  = base_s + {prod[PROD_BITS-1], prod};
   assign right_sum = base_s - {prod[PROD_BITS-1], prod};

   assign rsp_left_in  = finish(left_sum, min_duty_ff, max_duty_ff);
   assign rsp_right_in = finish(right_sum, min_duty_ff, max_duty_ff);
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_left_ff  <= rsp_left_in;
         rsp_right_ff <= rsp_right_in;
         rsp_lrev_ff  <= s1_lrev_ff;
         rsp_rrev_ff  <= s1_rrev_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_duty     = rsp_left_ff;
   assign rsp_right_duty    = rsp_right_ff;
   assign rsp_left_reverse  = rsp_lrev_ff;
   assign rsp_right_reverse = rsp_rrev_ff;

   // a steer beat leaves both counters cleared
   a_steer_clears: assert property (@(posedge clock) disable iff (reset)
      steer_acc |=> (count_one_ff == '0) && (count_two_ff == '0))
      else $error("counters not cleared after steer beat");

   // back-pressure only when both stages hold a beat
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with a free stage");

   // unchanged pins never move motor one's counter
   a_no_step: assert property (@(posedge clock) disable iff (reset)
      (enc_acc && (req_encoder_pins[1:0] == last_one_ff)) |=> $stable(count_one_ff))
      else $error("counter moved without a pin change");

   // a delivered duty is a clamp bound or lies between them
   a_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_left_ff == max_duty_ff) || (rsp_left_ff == min_duty_ff)
                        || ((rsp_left_ff <= max_duty_ff) && (rsp_left_ff >= min_duty_ff))))
      else $error("left duty outside clamp range");

endmodule
